### rtl/slbd_pkg.sv
// shared types, register codes and zone arithmetic for the shift light bar driver
package slbd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PILL_COUNT    = 2'd0;
    localparam logic [1:0] REG_LIGHT_PATTERN = 2'd1;
    localparam logic [1:0] REG_RPM_MAX       = 2'd2;
    localparam logic [1:0] REG_SHIFT_POINT   = 2'd3;

    // register reset values
    localparam logic [5:0]  RST_PILL_COUNT  = 6'd10;
    localparam logic [15:0] RST_RPM_MAX     = 16'd8000;
    localparam logic [15:0] RST_SHIFT_POINT = 16'd58982;

    // rpm scale (10 << 16) and quotient width of the count divider
    localparam logic [19:0] FULL_SCALE = 20'd655360;
    localparam int          DIV_QW     = 6;
    localparam int          DIV_STAGES = DIV_QW + 1;
    localparam int          NUMC_W     = 43;
    localparam int          DEN_W      = 36;

    // floor(27n/100) and floor(18n/100) as multiply by reciprocal, shift 17
    localparam logic [21:0] GREEN_RECIP  = 22'd35397;
    localparam logic [21:0] YELLOW_RECIP = 22'd23598;
    localparam int          RECIP_SHIFT  = 17;

    // activation order codes
    typedef enum logic [1:0] {
        PAT_LEFT   = 2'd0,
        PAT_RIGHT  = 2'd1,
        PAT_ALT    = 2'd2,
        PAT_CENTRE = 2'd3
    } t_pattern;

    // live configuration, pill count already clamped
    typedef struct packed {
        logic [5:0]  pill_n;
        t_pattern    pattern;
        logic [15:0] rpm_max;
        logic [15:0] shift_point;
    } t_cfg;

    // one divider pipeline stage
    typedef struct packed {
        logic              vld;
        logic              zero;
        logic              sat;
        logic [NUMC_W-1:0] rem;
        logic [DEN_W-1:0]  den;
        logic [DIV_QW-1:0] q;
    } t_div;

    // green pills at each end
    function automatic logic [5:0] f_green(input logic [5:0] n);
        logic [21:0] prod;
        prod = 22'(n) * GREEN_RECIP;
        return {1'b0, prod[21:RECIP_SHIFT]};
    endfunction

    // yellow pills next to the green ones
    function automatic logic [5:0] f_yellow(input logic [5:0] n);
        logic [21:0] prod;
        prod = 22'(n) * YELLOW_RECIP;
        return {1'b0, prod[21:RECIP_SHIFT]};
    endfunction

endpackage

### rtl/slbd_cfg.sv
// configuration registers with pill count clamp
module slbd_cfg #(
    parameter int MAX_PILLS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output slbd_pkg::t_cfg    o_cfg
);
    import slbd_pkg::*;

    localparam logic [6:0] LP_MAX = 7'(MAX_PILLS);

    logic [5:0]  r_pill_count;
    t_pattern    r_light_pattern;
    logic [15:0] r_rpm_max;
    logic [15:0] r_shift_point;
    logic [6:0]  n_clamp;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pill_count    <= RST_PILL_COUNT;
            r_light_pattern <= PAT_LEFT;
            r_rpm_max       <= RST_RPM_MAX;
            r_shift_point   <= RST_SHIFT_POINT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PILL_COUNT:    r_pill_count    <= i_cfg_data[5:0];
                REG_LIGHT_PATTERN: r_light_pattern <= t_pattern'(i_cfg_data[1:0]);
                REG_RPM_MAX:       r_rpm_max       <= i_cfg_data;
                REG_SHIFT_POINT:   r_shift_point   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp pill count to the bar size
    always_comb begin
        n_clamp = ({1'b0, r_pill_count} > LP_MAX) ? LP_MAX : {1'b0, r_pill_count};
        o_cfg.pill_n      = n_clamp[5:0];
        o_cfg.pattern     = r_light_pattern;
        o_cfg.rpm_max     = r_rpm_max;
        o_cfg.shift_point = r_shift_point;
    end

endmodule

### rtl/slbd_front.sv
// input register and numerator/denominator stages of the lit count
module slbd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [15:0]    i_rpm,
    input  slbd_pkg::t_cfg i_cfg,
    output slbd_pkg::t_div o_div
);
    import slbd_pkg::*;

    logic        r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic [15:0] r_rpm1;
    logic [35:0] r_p2;
    logic [34:0] r_start2;
    logic [19:0] r_dfac2;
    logic [35:0] r_d3;
    logic [35:0] r_den3;
    logic        r_zero3;
    logic [41:0] r_num4;
    logic [35:0] r_den4;
    logic        r_zero4;
    logic [NUMC_W-1:0] r_numc5;
    logic [35:0] r_den5;
    logic        r_zero5;

    logic [19:0] n_rpm10;
    logic [18:0] n_s7;
    logic [34:0] n_start;
    logic [19:0] n_dfac;
    logic        n_ge;
    logic [35:0] n_d;
    logic [35:0] n_den;
    logic        n_zero;
    logic [41:0] n_num;
    logic [NUMC_W-1:0] n_numc;

    // stage 2: scaled speed, start point 7*s*rpm_max, span factor
    always_comb begin
        n_rpm10 = 20'({r_rpm1, 3'b000}) + 20'({r_rpm1, 1'b0});
        n_s7    = 19'({i_cfg.shift_point, 3'b000}) - 19'(i_cfg.shift_point);
        n_start = 35'(n_s7) * 35'(i_cfg.rpm_max);
        n_dfac  = FULL_SCALE - 20'(n_s7);
    end

    // stage 3: excess over start and the denominator
    always_comb begin
        n_ge   = r_p2 >= 36'(r_start2);
        n_d    = r_p2 - 36'(r_start2);
        n_den  = 36'(r_dfac2) * 36'(i_cfg.rpm_max);
        n_zero = !n_ge || (i_cfg.pill_n == 6'd0) || (i_cfg.rpm_max == 16'd0);
    end

    // stage 4: scale by pill count, stage 5: bias for the ceiling
    always_comb begin
        n_num  = 42'(r_d3) * 42'(i_cfg.pill_n);
        n_numc = NUMC_W'(r_num4) + NUMC_W'(r_den4) - NUMC_W'(1);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rpm1   <= i_rpm;
            r_p2     <= {n_rpm10, 16'h0000};
            r_start2 <= n_start;
            r_dfac2  <= n_dfac;
            r_d3     <= n_d;
            r_den3   <= n_den;
            r_zero3  <= n_zero;
            r_num4   <= n_num;
            r_den4   <= r_den3;
            r_zero4  <= r_zero3;
            r_numc5  <= n_numc;
            r_den5   <= r_den4;
            r_zero5  <= r_zero4;
        end
    end

    always_comb begin
        o_div.vld  = r_vld5;
        o_div.zero = r_zero5;
        o_div.sat  = 1'b0;
        o_div.rem  = r_numc5;
        o_div.den  = r_den5;
        o_div.q    = '0;
    end

endmodule

### rtl/slbd_div.sv
// restoring divider, one quotient bit per stage, first stage flags overflow
module slbd_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  slbd_pkg::t_div i_div,
    output slbd_pkg::t_div o_div
);
    import slbd_pkg::*;

    t_div r_stg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        localparam int B = DIV_QW - s;
        t_div              src;
        t_div              n_stg;
        logic [NUMC_W-1:0] dsh;
        logic              take;

        if (s == 0) begin : g_src_in
            assign src = i_div;
        end else begin : g_src_prev
            assign src = r_stg[s-1];
        end

        assign dsh  = {{(NUMC_W-DEN_W){1'b0}}, src.den} << B;
        assign take = src.rem >= dsh;

        // top stage only detects a quotient beyond the field
        if (s == 0) begin : g_sat
            always_comb begin
                n_stg     = src;
                n_stg.sat = take;
            end
        end else begin : g_bit
            always_comb begin
                n_stg = src;
                if (take) begin
                    n_stg.rem  = src.rem - dsh;
                    n_stg.q[B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[s].vld <= 1'b0;
            end else if (i_en) begin
                r_stg[s].vld <= n_stg.vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[s].zero <= n_stg.zero;
                r_stg[s].sat  <= n_stg.sat;
                r_stg[s].rem  <= n_stg.rem;
                r_stg[s].den  <= n_stg.den;
                r_stg[s].q    <= n_stg.q;
            end
        end
    end

    assign o_div = r_stg[DIV_STAGES-1];

endmodule

### rtl/slbd_mask.sv
// count saturation and per-pill lit and zone masks, output register
module slbd_mask (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  slbd_pkg::t_div i_div,
    input  slbd_pkg::t_cfg i_cfg,
    output logic           o_vld,
    output logic [5:0]     o_cnt,
    output logic [31:0]    o_lit,
    output logic [31:0]    o_green,
    output logic [31:0]    o_yellow
);
    import slbd_pkg::*;

    logic        r_vld;
    logic [5:0]  r_cnt;
    logic [31:0] r_lit;
    logic [31:0] r_green;
    logic [31:0] r_yellow;

    logic [5:0]  n_cnt;
    logic [31:0] n_lit;
    logic [31:0] n_green;
    logic [31:0] n_yellow;
    logic [7:0]  n8;
    logic [7:0]  g8;
    logic [7:0]  gy8;

    // position of pill idx in the activation order, idx below n
    function automatic logic [7:0] f_pos(input logic [7:0] idx, input logic [7:0] n,
                                         input t_pattern pat);
        logic [7:0] mid;
        logic [7:0] rr;
        logic [7:0] d;
        logic [7:0] pa;
        logic [7:0] pb;
        logic [7:0] res;
        mid = n >> 1;
        rr  = n - mid - 8'd1;
        pa  = {idx[6:0], 1'b0};
        pb  = {rr[6:0] - idx[6:0] + mid[6:0], 1'b1};
        res = idx;
        unique case (pat)
            PAT_LEFT:  res = idx;
            PAT_RIGHT: res = n - 8'd1 - idx;
            PAT_ALT: begin
                pb  = {n[6:0] - 7'd1 - idx[6:0], 1'b1};
                res = (pa < pb) ? pa : pb;
            end
            PAT_CENTRE: begin
                if (idx == mid) begin
                    res = 8'd0;
                end else if (idx < mid) begin
                    d   = mid - idx;
                    res = (d <= rr) ? ({d[6:0], 1'b0} - 8'd1) : (rr + d);
                end else begin
                    d   = idx - mid;
                    res = (d <= mid) ? {d[6:0], 1'b0} : (mid + d);
                end
            end
        endcase
        return res;
    endfunction

    // lit count, saturated to the pill count
    always_comb begin
        if (i_div.zero) begin
            n_cnt = 6'd0;
        end else if (i_div.sat || (i_div.q > i_cfg.pill_n)) begin
            n_cnt = i_cfg.pill_n;
        end else begin
            n_cnt = i_div.q;
        end
    end

    // per-pill masks
    always_comb begin
        n8  = {2'b00, i_cfg.pill_n};
        g8  = {2'b00, f_green(i_cfg.pill_n)};
        gy8 = g8 + {2'b00, f_yellow(i_cfg.pill_n)};
        for (int i = 0; i < 32; i++) begin
            if (8'(i) < n8) begin
                n_lit[i]    = f_pos(8'(i), n8, i_cfg.pattern) < {2'b00, n_cnt};
                n_green[i]  = (8'(i) < g8) || (8'(i) >= n8 - g8);
                n_yellow[i] = !n_green[i] && ((8'(i) < gy8) || (8'(i) >= n8 - gy8));
            end else begin
                n_lit[i]    = 1'b0;
                n_green[i]  = 1'b0;
                n_yellow[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_div.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt    <= n_cnt;
            r_lit    <= n_lit;
            r_green  <= n_green;
            r_yellow <= n_yellow;
        end
    end

    assign o_vld    = r_vld;
    assign o_cnt    = r_cnt;
    assign o_lit    = r_lit;
    assign o_green  = r_green;
    assign o_yellow = r_yellow;

endmodule

### rtl/shift_light_bar_driver.sv
// shift light bar driver: engine speed sample in, led bar pattern out
//
// Input channel (i_in_valid / o_in_ready) carries one rpm sample per beat.
// Output channel (o_out_valid / i_out_ready) carries one result beat per
// sample: lit pill count, lit mask and the green and yellow zone masks.
// The configuration port is a plain write: i_cfg_we, i_cfg_idx, i_cfg_data,
// with index 0 pill count, 1 light pattern, 2 full-scale rpm, 3 shift point.
// Configuration must be changed only while no sample is in flight; the
// block does not enforce this. The design is a 13-register pipeline:
// input register, four arithmetic stages, seven divider stages (an
// overflow check, then one quotient bit each) and the mask/output
// register. One sample is taken every cycle while the receiver keeps up.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; nothing is dropped or duplicated.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults (10 pills, left-to-right, 8000 rpm full scale, shift point 0.9).
module shift_light_bar_driver #(
    parameter int MAX_PILLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_rpm,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_active_count,
    output logic [31:0] o_lit_mask,
    output logic [31:0] o_green_mask,
    output logic [31:0] o_yellow_mask,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import slbd_pkg::*;

    t_cfg cfg;
    t_div front_div;
    t_div div_out;
    logic en;

    // global advance: move when the output slot is free or being taken
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    slbd_cfg #(
        .MAX_PILLS (MAX_PILLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    slbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_rpm   (i_rpm),
        .i_cfg   (cfg),
        .o_div   (front_div)
    );

    slbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_div   (front_div),
        .o_div   (div_out)
    );

    slbd_mask u_mask (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_div    (div_out),
        .i_cfg    (cfg),
        .o_vld    (o_out_valid),
        .o_cnt    (o_active_count),
        .o_lit    (o_lit_mask),
        .o_green  (o_green_mask),
        .o_yellow (o_yellow_mask)
    );

    // count never exceeds the pill count
    a_cnt_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_active_count <= cfg.pill_n))
        else $error("lit count above pill count");

    // activation order lights exactly count pills
    a_lit_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (cfg.pill_n <= 6'd32)) |->
        ($countones(o_lit_mask) == int'(o_active_count)))
        else $error("lit mask population differs from count");

    // color zones do not overlap
    a_zone_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_green_mask & o_yellow_mask) == 32'h0))
        else $error("green and yellow zones overlap");

    // disabled bar lights nothing
    a_bar_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (cfg.rpm_max == 16'd0)) |->
        ((o_active_count == 6'd0) && (o_lit_mask == 32'h0)))
        else $error("bar lit while disabled");

endmodule

### bench/shift_light_bar_driver_tb.sv
// self-checking testbench for the shift light bar driver
`timescale 1ns / 1ps

module shift_light_bar_driver_tb;
    import slbd_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int RAND_PHASES = 28;
    localparam int PHASE_BEATS = 64;

    // one result beat: lit count and the three masks
    typedef struct packed {
        logic [5:0]  cnt;
        logic [31:0] lit;
        logic [31:0] grn;
        logic [31:0] yel;
    } t_bar;

    // one directed probe: settings, speed, and an optional typed result
    typedef struct {
        logic [5:0]  pills;
        t_pattern    pattern;
        logic [15:0] rpm_max;
        logic [15:0] shift;
        logic [15:0] speed;
        bit          typed;
        t_bar        res;
    } t_probe;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rpm_valid = 1'b0;
    logic        rpm_ready;
    logic [15:0] rpm = '0;
    logic        bar_valid;
    logic        bar_ready = 1'b0;
    logic [5:0]  active_count;
    logic [31:0] lit_mask;
    logic [31:0] green_mask;
    logic [31:0] yellow_mask;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = REG_PILL_COUNT;
    logic [15:0] cfg_data = '0;

    // mirror of the configuration registers
    logic [5:0]  cfg_pills = RST_PILL_COUNT;
    t_pattern    cfg_pattern = PAT_LEFT;
    logic [15:0] cfg_rpm_max = RST_RPM_MAX;
    logic [15:0] cfg_shift = RST_SHIFT_POINT;

    t_bar   pending_bars[$];
    t_probe probes[$];
    int     n_errors = 0;
    bit     sender_calm = 1'b0;
    bit     sink_calm = 1'b0;
    bit     hold_req = 1'b0;

    shift_light_bar_driver u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (rpm_valid),
        .o_in_ready     (rpm_ready),
        .i_rpm          (rpm),
        .o_out_valid    (bar_valid),
        .i_out_ready    (bar_ready),
        .o_active_count (active_count),
        .o_lit_mask     (lit_mask),
        .o_green_mask   (green_mask),
        .o_yellow_mask  (yellow_mask),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // number of lit pills for a speed sample under the mirrored settings
    function automatic int lit_pills(int n, logic [15:0] speed);
        longint unsigned start, scaled, num, den, c;
        if (n == 0 || cfg_rpm_max == 0) return 0;
        start  = 64'd7 * cfg_shift * cfg_rpm_max;
        scaled = 64'd655360 * speed;
        if (scaled < start) return 0;
        num = longint'(n) * (scaled - start);
        den = 64'(cfg_rpm_max) * (64'd655360 - 64'd7 * cfg_shift);
        c = (num + den - 1) / den;
        return (c > n) ? n : int'(c);
    endfunction

    // pill index at position k of the activation order
    function automatic int pill_at(int n, int k);
        int mid, step;
        case (cfg_pattern)
            PAT_LEFT:  return k;
            PAT_RIGHT: return n - 1 - k;
            PAT_ALT:   return (k % 2 == 1) ? (n - 1 - k / 2) : (k / 2);
            default: begin
                mid = n / 2;
                if (k == 0) return mid;
                step = (k + 1) / 2;
                if (mid >= step && mid + step < n)
                    return (k % 2 == 1) ? (mid - step) : (mid + step);
                // one side used up: the rest come from the longer side
                if (n - mid - 1 < mid) return mid - (k - (n - mid - 1));
                return mid + (k - mid);
            end
        endcase
    endfunction

    // full result beat for one speed sample
    function automatic t_bar predict_bar(logic [15:0] speed);
        t_bar res;
        int   n, g, y;
        n = (cfg_pills > 32) ? 32 : int'(cfg_pills);
        res = '0;
        res.cnt = 6'(lit_pills(n, speed));
        for (int k = 0; k < res.cnt; k++) res.lit[pill_at(n, k)] = 1'b1;
        g = (27 * n) / 100;
        y = (9 * n) / 50;
        for (int i = 0; i < n; i++) begin
            if (i < g || i >= n - g) res.grn[i] = 1'b1;
            else if (i < g + y || i >= n - g - y) res.yel[i] = 1'b1;
        end
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // speeds mostly inside the ramp of the bar, the rest anywhere
    function automatic logic [15:0] pick_rpm();
        longint unsigned lo;
        lo = (64'd7 * cfg_shift * cfg_rpm_max) / 64'd655360;
        if ($urandom_range(0, 99) < 65)
            return 16'($urandom_range(int'(cfg_rpm_max), int'(lo)));
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    task automatic add_probe(logic [5:0] pills, t_pattern pattern, logic [15:0] rmax,
                             logic [15:0] shift, logic [15:0] speed, bit typed, t_bar res);
        t_probe pr;
        pr.pills = pills;
        pr.pattern = pattern;
        pr.rpm_max = rmax;
        pr.shift = shift;
        pr.speed = speed;
        pr.typed = typed;
        pr.res = res;
        probes.push_back(pr);
    endtask

    // offer one speed beat, then log what it should produce
    task automatic send_rpm(logic [15:0] speed, bit typed, t_bar typed_res);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            rpm_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rpm_valid <= 1'b1;
        rpm <= speed;
        do @(posedge clk); while (!(rpm_valid && rpm_ready));
        pending_bars.push_back(typed ? typed_res : predict_bar(speed));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        rpm_valid <= 1'b0;
        while (pending_bars.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // write all four registers and update the mirror
    task automatic program_bar(logic [15:0] pc_word, logic [15:0] pat_word,
                               logic [15:0] rmax, logic [15:0] shift);
        write_reg(REG_PILL_COUNT, pc_word);
        write_reg(REG_LIGHT_PATTERN, pat_word);
        write_reg(REG_RPM_MAX, rmax);
        write_reg(REG_SHIFT_POINT, shift);
        cfg_we <= 1'b0;
        cfg_pills = pc_word[5:0];
        cfg_pattern = t_pattern'(pat_word[1:0]);
        cfg_rpm_max = rmax;
        cfg_shift = shift;
    endtask

    // main stimulus
    initial begin : stimulus
        t_probe      pr;
        logic [5:0]  pc;
        t_pattern    pat;
        logic [15:0] rmax, shift;
        int          r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first, then each special case
        add_probe(6'd10, PAT_LEFT, 16'd8000, 16'd58982, 16'd0, 1,
                  '{6'd0, 32'h0, 32'h0000_0303, 32'h0000_0084});
        add_probe(6'd10, PAT_LEFT, 16'd8000, 16'd58982, 16'hffff, 1,
                  '{6'd10, 32'h0000_03ff, 32'h0000_0303, 32'h0000_0084});
        add_probe(6'd10, PAT_LEFT, 16'd8000, 16'd58982, 16'd7000, 0, '0);
        add_probe(6'd10, PAT_LEFT, 16'd8000, 16'd58982, 16'd5000, 0, '0);
        add_probe(6'd10, PAT_LEFT, 16'd8000, 16'd58982, 16'd5041, 0, '0);
        add_probe(6'd10, PAT_RIGHT, 16'd8000, 16'd58982, 16'd7500, 0, '0);
        add_probe(6'd10, PAT_ALT, 16'd8000, 16'd58982, 16'd7500, 0, '0);
        add_probe(6'd10, PAT_CENTRE, 16'd8000, 16'd58982, 16'd7500, 0, '0);
        // empty bar
        add_probe(6'd0, PAT_CENTRE, 16'd8000, 16'd58982, 16'hffff, 1, '0);
        // more pills than the bar holds
        add_probe(6'd63, PAT_LEFT, 16'd8000, 16'd58982, 16'hffff, 1,
                  '{6'd32, 32'hffff_ffff, 32'hff00_00ff, 32'h00f8_1f00});
        add_probe(6'd63, PAT_CENTRE, 16'd8000, 16'd58982, 16'd6500, 0, '0);
        add_probe(6'd33, PAT_RIGHT, 16'd8000, 16'd58982, 16'd7100, 0, '0);
        add_probe(6'd32, PAT_ALT, 16'd8000, 16'd58982, 16'd7000, 0, '0);
        add_probe(6'd31, PAT_CENTRE, 16'd8000, 16'd58982, 16'd7200, 0, '0);
        add_probe(6'd2, PAT_CENTRE, 16'd8000, 16'd58982, 16'd7900, 0, '0);
        // bar disabled: zones still shown
        add_probe(6'd10, PAT_LEFT, 16'd0, 16'd58982, 16'hffff, 1,
                  '{6'd0, 32'h0, 32'h0000_0303, 32'h0000_0084});
        // zero shift point and full scale extremes
        add_probe(6'd10, PAT_LEFT, 16'hffff, 16'd0, 16'd0, 0, '0);
        add_probe(6'd10, PAT_LEFT, 16'hffff, 16'd0, 16'd1, 0, '0);
        add_probe(6'd10, PAT_ALT, 16'hffff, 16'hffff, 16'hffff, 0, '0);
        add_probe(6'd10, PAT_ALT, 16'hffff, 16'hffff, 16'd45875, 0, '0);
        // single pill, speed above full scale
        add_probe(6'd1, PAT_LEFT, 16'd1, 16'd58982, 16'hffff, 1,
                  '{6'd1, 32'h1, 32'h0, 32'h0});
        add_probe(6'd1, PAT_CENTRE, 16'd1, 16'd58982, 16'd0, 0, '0);

        // directed table walk
        foreach (probes[i]) begin
            pr = probes[i];
            if (pr.pills != cfg_pills || pr.pattern != cfg_pattern ||
                pr.rpm_max != cfg_rpm_max || pr.shift != cfg_shift) begin
                wait_drained();
                program_bar({10'd0, pr.pills}, {14'd0, pr.pattern}, pr.rpm_max, pr.shift);
            end
            send_rpm(pr.speed, pr.typed, pr.res);
        end

        // random phases, extreme settings first
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin pc = 6'd63; pat = PAT_CENTRE; rmax = 16'hffff; shift = 16'hffff; end
                1: begin pc = 6'd0;  pat = PAT_ALT;    rmax = 16'd1;    shift = 16'd0;    end
                2: begin pc = 6'd32; pat = PAT_LEFT;   rmax = 16'd12000; shift = 16'd58982; end
                3: begin pc = 6'd1;  pat = PAT_RIGHT;  rmax = 16'd0;    shift = 16'd40000; end
                4: begin pc = 6'd31; pat = PAT_CENTRE; rmax = 16'd9000; shift = 16'd30000; end
                5: begin pc = 6'd17; pat = PAT_ALT;    rmax = 16'd7000; shift = 16'hffff; end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 15) pc = 6'($urandom_range(0, 4));
                    else if (r < 30) pc = 6'($urandom_range(33, 63));
                    else pc = 6'($urandom_range(5, 32));
                    pat = t_pattern'($urandom_range(0, 3));
                    r = $urandom_range(0, 99);
                    if (r < 8) rmax = 16'd0;
                    else if (r < 16) rmax = 16'hffff;
                    else if (r < 26) rmax = 16'($urandom_range(1, 100));
                    else if (r < 70) rmax = 16'($urandom_range(1000, 20000));
                    else rmax = 16'($urandom);
                    r = $urandom_range(0, 99);
                    if (r < 10) shift = 16'd0;
                    else if (r < 20) shift = 16'hffff;
                    else shift = 16'($urandom);
                end
            endcase
            program_bar({10'($urandom), pc}, {14'($urandom), pat}, rmax, shift);
            sender_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            // long receiver stall while the sender keeps offering
            if (p == 2) begin
                sender_calm = 1'b1;
                sink_calm = 1'b0;
                hold_req = 1'b1;
            end
            repeat (PHASE_BEATS) send_rpm(pick_rpm(), 0, '0);
        end

        wait_drained();
        repeat (24) @(posedge clk);
        if (n_errors == 0) begin
            $display("shift_light_bar_driver_tb: clean");
        end else begin
            $display("shift_light_bar_driver_tb: errors");
        end
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    initial begin : sink
        int lull;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                bar_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            lull = pick_gap(sink_calm);
            if (lull > 0) begin
                bar_ready <= 1'b0;
                repeat (lull) @(posedge clk);
            end
            bar_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk) begin
        t_bar want;
        if (rst_n && bar_valid && bar_ready) begin
            if (pending_bars.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(active_count), '0);
            end else begin
                want = pending_bars.pop_front();
                if (active_count !== want.cnt)
                    report_mismatch("active_count", 32'(active_count), 32'(want.cnt));
                if (lit_mask !== want.lit)
                    report_mismatch("lit_mask", lit_mask, want.lit);
                if (green_mask !== want.grn)
                    report_mismatch("green_mask", green_mask, want.grn);
                if (yellow_mask !== want.yel)
                    report_mismatch("yellow_mask", yellow_mask, want.yel);
            end
        end
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("shift_light_bar_driver_tb: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/slbd_pkg.sv
rtl/slbd_cfg.sv
rtl/slbd_front.sv
rtl/slbd_div.sv
rtl/slbd_mask.sv
rtl/shift_light_bar_driver.sv
bench/shift_light_bar_driver_tb.sv
